// ===== src/owtr_pkg.sv =====
// Shared types and constants for the one-wire temperature reader.
// Holds the tick and status payloads, the configuration record and register indexes.
// No dependencies.
package owtr_pkg;

	localparam int SCRATCH_READ_BYTES_DEF = 8;
	localparam int TICK_COUNT_WIDTH_DEF = 16;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
	localparam logic [7:0] CMD_CONVERT = 8'h44;
	localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

	localparam logic [9:0] RESET_LOW_DEF = 10'd500;
	localparam logic [7:0] PRESENCE_WINDOW_DEF = 8'd80;
	localparam logic [9:0] RELEASE_WAIT_DEF = 10'd300;
	localparam logic [7:0] WRITE_SLOT_DEF = 8'd70;
	localparam logic [5:0] READ_SAMPLE_DEF = 6'd15;
	localparam logic [7:0] READ_RECOVER_DEF = 8'd60;
	localparam logic [15:0] POLL_INTERVAL_DEF = 16'd10000;
	localparam logic [7:0] POLL_LIMIT_DEF = 8'd100;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RESET_LOW = 3'd0,
		REG_PRESENCE_WINDOW = 3'd1,
		REG_RELEASE_WAIT = 3'd2,
		REG_WRITE_SLOT = 3'd3,
		REG_READ_SAMPLE = 3'd4,
		REG_READ_RECOVER = 3'd5,
		REG_POLL_INTERVAL = 3'd6,
		REG_POLL_LIMIT = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic [9:0] reset_low_ticks;
		logic [7:0] presence_window_ticks;
		logic [9:0] release_wait_ticks;
		logic [7:0] write_slot_ticks;
		logic [5:0] read_sample_ticks;
		logic [7:0] read_recover_ticks;
		logic [15:0] poll_interval_ticks;
		logic [7:0] poll_limit;
	} cfg_t;

	typedef struct packed {
		logic start_req;
		logic line_level;
	} tick_item_t;

	typedef struct packed {
		logic drive_low;
		logic busy_res;
		logic done_res;
		logic [7:0] temperature;
		logic presence_seen;
		logic timed_out;
	} status_item_t;

endpackage

// ===== src/owtr_stream_if.sv =====
// Valid/ready channel carrying one payload per request.
// Depends on nothing; the payload type is given by the user.
interface owtr_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== src/one_wire_temperature_reader_core.sv =====
// Top level of the one-wire temperature reader: configuration registers,
// tick channel, sequencer and registered status channel.
// Depends on owtr_pkg, owtr_stream_if and owtr_seq.
//
//   channel  direction  payload
//   tick     in         start_req, line_level (one bus microsecond each)
//   status   out        drive_low, busy_res, done_res, temperature,
//                       presence_seen, timed_out
//   cfg      in         cfg_we, cfg_index, cfg_data (write only)
//
// Each tick request yields exactly one status request, registered in the cycle after the tick is accepted.
// A new tick is taken every cycle while the status register is empty or
// being emptied in the same cycle; a stalled status holds ticks off.
// Reset returns the sequencer to idle and the configuration registers to their defaults.
module one_wire_temperature_reader_core
	import owtr_pkg::*;
#(
	parameter int SCRATCH_READ_BYTES = SCRATCH_READ_BYTES_DEF,
	parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	owtr_stream_if.sink tick,
	owtr_stream_if.source status
);

	cfg_t cfg_q;
	status_item_t res_next;
	status_item_t status_q;
	logic status_valid_q;
	logic accept;

	assign tick.ready = !status_valid_q || status.ready;
	assign accept = tick.valid && tick.ready;
	assign status.valid = status_valid_q;
	assign status.payload = status_q;

	owtr_seq #(
		.SCRATCH_READ_BYTES(SCRATCH_READ_BYTES),
		.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.step_en(accept),
		.item(tick.payload),
		.cfg(cfg_q),
		.result(res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_ticks <= RESET_LOW_DEF;
			cfg_q.presence_window_ticks <= PRESENCE_WINDOW_DEF;
			cfg_q.release_wait_ticks <= RELEASE_WAIT_DEF;
			cfg_q.write_slot_ticks <= WRITE_SLOT_DEF;
			cfg_q.read_sample_ticks <= READ_SAMPLE_DEF;
			cfg_q.read_recover_ticks <= READ_RECOVER_DEF;
			cfg_q.poll_interval_ticks <= POLL_INTERVAL_DEF;
			cfg_q.poll_limit <= POLL_LIMIT_DEF;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_RESET_LOW: cfg_q.reset_low_ticks <= cfg_data[9:0];
				REG_PRESENCE_WINDOW: cfg_q.presence_window_ticks <= cfg_data[7:0];
				REG_RELEASE_WAIT: cfg_q.release_wait_ticks <= cfg_data[9:0];
				REG_WRITE_SLOT: cfg_q.write_slot_ticks <= cfg_data[7:0];
				REG_READ_SAMPLE: cfg_q.read_sample_ticks <= cfg_data[5:0];
				REG_READ_RECOVER: cfg_q.read_recover_ticks <= cfg_data[7:0];
				REG_POLL_INTERVAL: cfg_q.poll_interval_ticks <= cfg_data;
				REG_POLL_LIMIT: cfg_q.poll_limit <= cfg_data[7:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_valid_q <= 1'b0;
		end else if (accept) begin
			status_valid_q <= 1'b1;
		end else if (status.ready) begin
			status_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= res_next;
		end
	end

endmodule

// ===== src/owtr_seq.sv =====
// Bus sequencer: reset, presence, command writes, status polls and scratchpad reads.
// Advances one tick per accepted request and gives the status for that tick.
// Depends on owtr_pkg.
module owtr_seq
	import owtr_pkg::*;
#(
	parameter int SCRATCH_READ_BYTES = SCRATCH_READ_BYTES_DEF,
	parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step_en,
	input  tick_item_t item,
	input  cfg_t cfg,
	output status_item_t result
);

	localparam int TW = TICK_COUNT_WIDTH;
	localparam int CW = (TW > 17) ? TW : 17;
	localparam logic [TW-1:0] TC_MAX = '1;
	localparam logic [CW-1:0] TC_MAX_X = CW'(TC_MAX);
	localparam logic [CW-1:0] LOW_TICKS = CW'(2);
	localparam logic [3:0] LAST_BYTE = 4'(SCRATCH_READ_BYTES);

	typedef enum logic [3:0] {
		PH_IDLE, PH_RST_A, PH_PRES_A, PH_REL_A, PH_WR_SKIP_A, PH_WR_CONV,
		PH_POLL_READ, PH_POLL_GAP, PH_RST_B, PH_PRES_B, PH_REL_B, PH_WR_SKIP_B,
		PH_WR_SCRATCH, PH_READ_SP
	} phase_t;

	function automatic logic [CW-1:0] clip(input logic [CW-1:0] v);
		return (v > TC_MAX_X) ? TC_MAX_X : v;
	endfunction

	phase_t phase_q, n_phase;
	logic [TW-1:0] tick_q, n_tick, tick_inc;
	logic [2:0] bit_q, n_bit;
	logic [7:0] shift_q, n_shift, rd_shift;
	logic [3:0] byte_q, n_byte;
	logic [7:0] poll_q, n_poll;
	logic [7:0] low_q, n_low;
	logic [3:0] hi_q, n_hi;
	logic pres_q, n_pres;

	logic [CW-1:0] lim_rst, lim_pres, lim_rel, lim_wr, lim_rd, lim_gap, lim_sel;
	logic [CW-1:0] sample_at, wr_drive_end, n_tick_x;
	logic hit, last_bit, done, tout;
	logic [7:0] temp;

	always_comb begin
		lim_rst = clip(CW'(cfg.reset_low_ticks));
		lim_pres = clip(CW'(cfg.presence_window_ticks));
		lim_rel = clip(CW'(cfg.release_wait_ticks));
		lim_wr = clip(CW'(cfg.write_slot_ticks) + CW'(3));
		lim_rd = clip(CW'(cfg.read_sample_ticks) + CW'(cfg.read_recover_ticks) + CW'(2));
		lim_gap = clip(CW'(cfg.poll_interval_ticks));
		sample_at = CW'(cfg.read_sample_ticks) + CW'(1);
		wr_drive_end = CW'(cfg.write_slot_ticks) + CW'(2);
	end

	always_comb begin
		unique case (phase_q)
			PH_RST_A, PH_RST_B: lim_sel = lim_rst;
			PH_PRES_A, PH_PRES_B: lim_sel = lim_pres;
			PH_WR_SKIP_A, PH_WR_CONV, PH_WR_SKIP_B, PH_WR_SCRATCH: lim_sel = lim_wr;
			PH_POLL_READ, PH_READ_SP: lim_sel = lim_rd;
			PH_POLL_GAP: lim_sel = lim_gap;
			default: lim_sel = lim_rst;
		endcase
	end

	always_comb begin
		tick_inc = (tick_q == TC_MAX) ? tick_q : tick_q + 1'b1;
		hit = CW'(tick_inc) >= lim_sel;
		last_bit = (bit_q == 3'd7);
		rd_shift = (CW'(tick_q) == sample_at) ? {item.line_level, shift_q[7:1]} : shift_q;

		n_phase = phase_q;
		n_tick = tick_q;
		n_bit = bit_q;
		n_shift = shift_q;
		n_byte = byte_q;
		n_poll = poll_q;
		n_low = low_q;
		n_hi = hi_q;
		n_pres = pres_q;
		done = 1'b0;
		tout = 1'b0;
		temp = 8'd0;

		unique case (phase_q)
			PH_IDLE: begin
				if (item.start_req) begin
					n_phase = PH_RST_A;
					n_tick = '0;
					n_pres = 1'b0;
				end
			end
			PH_RST_A, PH_RST_B: begin
				n_tick = tick_inc;
				if (hit) begin
					n_phase = (phase_q == PH_RST_A) ? PH_PRES_A : PH_PRES_B;
					n_tick = '0;
				end
			end
			PH_PRES_A, PH_PRES_B: begin
				if (!item.line_level) begin
					n_pres = 1'b1;
					n_phase = (phase_q == PH_PRES_B) ? PH_REL_B : PH_REL_A;
					n_tick = '0;
				end else begin
					n_tick = tick_inc;
					if (hit) begin
						n_phase = (phase_q == PH_PRES_B) ? PH_WR_SKIP_B : PH_WR_SKIP_A;
						n_shift = CMD_SKIP_ROM;
						n_bit = '0;
						n_tick = '0;
					end
				end
			end
			PH_REL_A, PH_REL_B: begin
				if (item.line_level || (CW'(tick_q) >= lim_rel)) begin
					n_phase = (phase_q == PH_REL_B) ? PH_WR_SKIP_B : PH_WR_SKIP_A;
					n_shift = CMD_SKIP_ROM;
					n_bit = '0;
					n_tick = '0;
				end else begin
					n_tick = tick_inc;
				end
			end
			PH_WR_SKIP_A, PH_WR_CONV, PH_WR_SKIP_B, PH_WR_SCRATCH: begin
				n_tick = tick_inc;
				if (hit) begin
					n_shift = {1'b0, shift_q[7:1]};
					n_bit = bit_q + 3'd1;
					n_tick = '0;
					if (last_bit) begin
						unique case (phase_q)
							PH_WR_SKIP_A: begin
								n_phase = PH_WR_CONV;
								n_shift = CMD_CONVERT;
							end
							PH_WR_CONV: begin
								n_phase = PH_POLL_READ;
								n_shift = 8'd0;
								n_poll = 8'd0;
							end
							PH_WR_SKIP_B: begin
								n_phase = PH_WR_SCRATCH;
								n_shift = CMD_READ_SCRATCH;
							end
							default: begin
								n_phase = PH_READ_SP;
								n_shift = 8'd0;
								n_byte = 4'd0;
							end
						endcase
					end
				end
			end
			PH_POLL_READ: begin
				n_shift = rd_shift;
				n_tick = tick_inc;
				if (hit) begin
					n_bit = bit_q + 3'd1;
					n_tick = '0;
					if (last_bit) begin
						if (rd_shift != 8'd0) begin
							n_phase = PH_RST_B;
							n_pres = 1'b0;
						end else begin
							n_poll = poll_q + 8'd1;
							if (n_poll >= cfg.poll_limit) begin
								n_phase = PH_IDLE;
								done = 1'b1;
								tout = 1'b1;
							end else begin
								n_phase = PH_POLL_GAP;
							end
						end
					end
				end
			end
			PH_POLL_GAP: begin
				n_tick = tick_inc;
				if (hit) begin
					n_phase = PH_POLL_READ;
					n_shift = 8'd0;
					n_bit = '0;
					n_tick = '0;
				end
			end
			PH_READ_SP: begin
				n_shift = rd_shift;
				n_tick = tick_inc;
				if (hit) begin
					n_bit = bit_q + 3'd1;
					n_tick = '0;
					if (last_bit) begin
						if (byte_q == 4'd0) begin
							n_low = rd_shift;
						end else if (byte_q == 4'd1) begin
							n_hi = rd_shift[3:0];
						end
						n_byte = byte_q + 4'd1;
						n_shift = 8'd0;
						if (n_byte >= LAST_BYTE) begin
							n_phase = PH_IDLE;
							done = 1'b1;
							temp = {n_hi, n_low[7:4]};
						end
					end
				end
			end
			default: begin
				n_phase = PH_IDLE;
				n_tick = '0;
			end
		endcase
	end

	always_comb begin
		n_tick_x = CW'(n_tick);
		result.drive_low = 1'b0;
		unique case (n_phase)
			PH_RST_A, PH_RST_B: result.drive_low = 1'b1;
			PH_WR_SKIP_A, PH_WR_CONV, PH_WR_SKIP_B, PH_WR_SCRATCH: begin
				if (n_tick_x < LOW_TICKS) begin
					result.drive_low = 1'b1;
				end else if (n_tick_x < wr_drive_end) begin
					result.drive_low = ~n_shift[0];
				end
			end
			PH_POLL_READ, PH_READ_SP: result.drive_low = (n_tick_x < LOW_TICKS);
			default: result.drive_low = 1'b0;
		endcase
		result.busy_res = (n_phase != PH_IDLE);
		result.done_res = done;
		result.temperature = temp;
		result.presence_seen = n_pres;
		result.timed_out = tout;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q <= '0;
			bit_q <= '0;
			shift_q <= '0;
			byte_q <= '0;
			poll_q <= '0;
			low_q <= '0;
			hi_q <= '0;
			pres_q <= 1'b0;
		end else if (step_en) begin
			phase_q <= n_phase;
			tick_q <= n_tick;
			bit_q <= n_bit;
			shift_q <= n_shift;
			byte_q <= n_byte;
			poll_q <= n_poll;
			low_q <= n_low;
			hi_q <= n_hi;
			pres_q <= n_pres;
		end
	end

`ifndef SYNTHESIS
	// A timed-out sequence reports completion with a zero reading.
	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.timed_out |-> result.done_res && (result.temperature == 8'd0))
		else $error("timeout without done or with a nonzero reading");

	// A start request taken while idle begins the first reset pulse.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && (phase_q == PH_IDLE) && item.start_req |=> phase_q == PH_RST_A)
		else $error("start request did not begin a reset pulse");

	// Completion always returns the sequencer to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && result.done_res |=> phase_q == PH_IDLE)
		else $error("sequencer not idle after completion");

	// Without a request the sequencer holds its place.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(phase_q) && $stable(tick_q) && $stable(bit_q))
		else $error("sequencer moved without a request");
`endif

endmodule

// ===== verif/owtr_status_checker.sv =====
`timescale 1ns / 1ps
// Status checker for the one-wire temperature reader: it predicts the status of every
// accepted tick request with its own sequencer model and compares the block's status with it.
// Depends on owtr_pkg.
module owtr_status_checker
	import owtr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic tick_valid,
	input  logic tick_ready,
	input  tick_item_t tick_item,
	input  logic status_valid,
	input  logic status_ready,
	input  status_item_t status_item,
	output int fail_count,
	output int pending_cnt
);

	localparam int unsigned TICK_MAX = (1 << TICK_COUNT_WIDTH_DEF) - 1;
	localparam int SCRATCH_BYTES = SCRATCH_READ_BYTES_DEF;

	typedef enum logic [4:0] {
		BUS_IDLE,
		RESET_PULSE_1,
		PRESENCE_1,
		RELEASE_1,
		SEND_SKIP_1,
		SEND_CONVERT,
		POLL_SLOT,
		POLL_WAIT,
		RESET_PULSE_2,
		PRESENCE_2,
		RELEASE_2,
		SEND_SKIP_2,
		SEND_READ_CMD,
		SCRATCH_SLOT
	} bus_phase_t;

	cfg_t regs;
	bus_phase_t phase;
	int unsigned ticks;
	logic [2:0] bit_pos;
	logic [7:0] shreg;
	logic [3:0] bytes_read;
	logic [7:0] polls;
	logic [7:0] low_byte;
	logic [3:0] high_nib;
	logic presence;
	status_item_t status_due_q[$];

	function automatic int unsigned clip_ticks(input int unsigned v);
		return (v > TICK_MAX) ? TICK_MAX : v;
	endfunction

	function automatic void count_tick();
		if (ticks < TICK_MAX)
			ticks++;
	endfunction

	function automatic void start_reset(input bus_phase_t p);
		phase = p;
		ticks = 0;
		presence = 1'b0;
	endfunction

	function automatic void load_byte(input bus_phase_t p, input logic [7:0] v);
		phase = p;
		shreg = v;
		bit_pos = 3'd0;
		ticks = 0;
	endfunction

	function automatic bit write_slot_over();
		count_tick();
		if (ticks < clip_ticks(regs.write_slot_ticks + 3))
			return 1'b0;
		shreg = shreg >> 1;
		bit_pos = bit_pos + 3'd1;
		ticks = 0;
		return bit_pos == 3'd0;
	endfunction

	function automatic bit read_slot_over(input logic line);
		if (ticks == regs.read_sample_ticks + 1)
			shreg = {line, shreg[7:1]};
		count_tick();
		if (ticks < clip_ticks(regs.read_sample_ticks + regs.read_recover_ticks + 2))
			return 1'b0;
		bit_pos = bit_pos + 3'd1;
		ticks = 0;
		return bit_pos == 3'd0;
	endfunction

	function automatic logic bus_drive();
		case (phase)
			RESET_PULSE_1, RESET_PULSE_2: return 1'b1;
			SEND_SKIP_1, SEND_CONVERT, SEND_SKIP_2, SEND_READ_CMD: begin
				if (ticks < 2)
					return 1'b1;
				if (ticks < regs.write_slot_ticks + 2)
					return !shreg[0];
				return 1'b0;
			end
			POLL_SLOT, SCRATCH_SLOT: return ticks < 2;
			default: return 1'b0;
		endcase
	endfunction

	function automatic status_item_t sequencer_step(input tick_item_t t);
		status_item_t s;
		bit second;
		s = '0;
		case (phase)
			BUS_IDLE: begin
				if (t.start_req)
					start_reset(RESET_PULSE_1);
			end
			RESET_PULSE_1, RESET_PULSE_2: begin
				count_tick();
				if (ticks >= clip_ticks(regs.reset_low_ticks)) begin
					phase = (phase == RESET_PULSE_1) ? PRESENCE_1 : PRESENCE_2;
					ticks = 0;
				end
			end
			PRESENCE_1, PRESENCE_2: begin
				second = (phase == PRESENCE_2);
				if (!t.line_level) begin
					presence = 1'b1;
					phase = second ? RELEASE_2 : RELEASE_1;
					ticks = 0;
				end else begin
					count_tick();
					if (ticks >= clip_ticks(regs.presence_window_ticks))
						load_byte(second ? SEND_SKIP_2 : SEND_SKIP_1, CMD_SKIP_ROM);
				end
			end
			RELEASE_1, RELEASE_2: begin
				second = (phase == RELEASE_2);
				if (t.line_level || ticks >= clip_ticks(regs.release_wait_ticks))
					load_byte(second ? SEND_SKIP_2 : SEND_SKIP_1, CMD_SKIP_ROM);
				else
					count_tick();
			end
			SEND_SKIP_1: begin
				if (write_slot_over())
					load_byte(SEND_CONVERT, CMD_CONVERT);
			end
			SEND_CONVERT: begin
				if (write_slot_over()) begin
					load_byte(POLL_SLOT, 8'h00);
					polls = 8'd0;
				end
			end
			POLL_SLOT: begin
				if (read_slot_over(t.line_level)) begin
					if (shreg != 8'h00) begin
						start_reset(RESET_PULSE_2);
					end else begin
						polls = polls + 8'd1;
						ticks = 0;
						if (polls >= regs.poll_limit) begin
							phase = BUS_IDLE;
							s.done_res = 1'b1;
							s.timed_out = 1'b1;
						end else begin
							phase = POLL_WAIT;
						end
					end
				end
			end
			POLL_WAIT: begin
				count_tick();
				if (ticks >= clip_ticks(regs.poll_interval_ticks))
					load_byte(POLL_SLOT, 8'h00);
			end
			SEND_SKIP_2: begin
				if (write_slot_over())
					load_byte(SEND_READ_CMD, CMD_READ_SCRATCH);
			end
			SEND_READ_CMD: begin
				if (write_slot_over()) begin
					load_byte(SCRATCH_SLOT, 8'h00);
					bytes_read = 4'd0;
				end
			end
			SCRATCH_SLOT: begin
				if (read_slot_over(t.line_level)) begin
					if (bytes_read == 4'd0)
						low_byte = shreg;
					else if (bytes_read == 4'd1)
						high_nib = shreg[3:0];
					bytes_read = bytes_read + 4'd1;
					shreg = 8'h00;
					if (bytes_read >= SCRATCH_BYTES) begin
						phase = BUS_IDLE;
						ticks = 0;
						s.done_res = 1'b1;
						s.temperature = {high_nib, low_byte[7:4]};
					end
				end
			end
			default: begin
				phase = BUS_IDLE;
				ticks = 0;
			end
		endcase
		s.drive_low = bus_drive();
		s.busy_res = (phase != BUS_IDLE);
		s.presence_seen = presence;
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		status_item_t want;
		if (!arst_n) begin
			regs = '{RESET_LOW_DEF, PRESENCE_WINDOW_DEF, RELEASE_WAIT_DEF, WRITE_SLOT_DEF,
				READ_SAMPLE_DEF, READ_RECOVER_DEF, POLL_INTERVAL_DEF, POLL_LIMIT_DEF};
			phase = BUS_IDLE;
			ticks = 0;
			bit_pos = '0;
			shreg = '0;
			bytes_read = '0;
			polls = '0;
			low_byte = '0;
			high_nib = '0;
			presence = 1'b0;
			status_due_q.delete();
			fail_count = 0;
			pending_cnt <= 0;
		end else begin
			if (status_valid && status_ready) begin
				if (status_due_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: status request with no tick request outstanding", $time);
				end else begin
					want = status_due_q.pop_front();
					if (status_item.drive_low !== want.drive_low
							|| status_item.busy_res !== want.busy_res
							|| status_item.done_res !== want.done_res
							|| status_item.temperature !== want.temperature
							|| status_item.presence_seen !== want.presence_seen
							|| status_item.timed_out !== want.timed_out) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: status mismatch, expected drive_low %b busy %b done %b",
								$time, want.drive_low, want.busy_res, want.done_res);
							$display("  temperature %0d presence %b timed_out %b",
								want.temperature, want.presence_seen, want.timed_out);
							$display("  actual drive_low %b busy %b done %b",
								status_item.drive_low, status_item.busy_res, status_item.done_res);
							$display("  temperature %0d presence %b timed_out %b",
								status_item.temperature, status_item.presence_seen,
								status_item.timed_out);
						end
					end
				end
			end
			if (tick_valid && tick_ready)
				status_due_q.push_back(sequencer_step(tick_item));
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_RESET_LOW: regs.reset_low_ticks = cfg_data[9:0];
					REG_PRESENCE_WINDOW: regs.presence_window_ticks = cfg_data[7:0];
					REG_RELEASE_WAIT: regs.release_wait_ticks = cfg_data[9:0];
					REG_WRITE_SLOT: regs.write_slot_ticks = cfg_data[7:0];
					REG_READ_SAMPLE: regs.read_sample_ticks = cfg_data[5:0];
					REG_READ_RECOVER: regs.read_recover_ticks = cfg_data[7:0];
					REG_POLL_INTERVAL: regs.poll_interval_ticks = cfg_data[15:0];
					REG_POLL_LIMIT: regs.poll_limit = cfg_data[7:0];
					default: ;
				endcase
			end
			pending_cnt <= status_due_q.size();
		end
	end

endmodule

// ===== verif/tb_one_wire_temperature_reader_core.sv =====
`timescale 1ns / 1ps
// Testbench top for the one-wire temperature reader core: clock, reset, register writes
// and tick requests under varied idling; owtr_status_checker judges every status request.
// Depends on owtr_pkg, owtr_stream_if, one_wire_temperature_reader_core and the checker.
module tb_one_wire_temperature_reader_core;
	import owtr_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic tick_valid = 1'b0;
	tick_item_t tick_data = '0;
	logic status_ready = 1'b0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit pressure_on = 1'b0;
	bit held_once = 1'b0;
	int hold_left = 0;
	int fail_count;
	int pending_cnt;

	owtr_stream_if #(.payload_t(tick_item_t)) tick_ch ();
	owtr_stream_if #(.payload_t(status_item_t)) status_ch ();

	assign tick_ch.valid = tick_valid;
	assign tick_ch.payload = tick_data;
	assign status_ch.ready = status_ready;

	one_wire_temperature_reader_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.tick(tick_ch),
		.status(status_ch)
	);

	owtr_status_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.tick_valid(tick_ch.valid),
		.tick_ready(tick_ch.ready),
		.tick_item(tick_ch.payload),
		.status_valid(status_ch.valid),
		.status_ready(status_ch.ready),
		.status_item(status_ch.payload),
		.fail_count(fail_count),
		.pending_cnt(pending_cnt)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Under pressure the receiver holds off for long stretches so that the core fills up.
	always @(posedge clk) begin
		if (!arst_n) begin
			status_ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_left != 0) begin
			status_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (pressure_on && (!held_once || $urandom_range(0, 199) == 0)) begin
			status_ready <= 1'b0;
			hold_left <= $urandom_range(40, 80);
			held_once <= 1'b1;
		end else begin
			status_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	task automatic send_tick(input logic start, input logic line);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			tick_valid <= 1'b0;
			@(posedge clk);
		end
		tick_valid <= 1'b1;
		tick_data <= '{start_req: start, line_level: line};
		do
			@(posedge clk);
		while (!tick_ch.ready);
	endtask

	task automatic drain();
		tick_valid <= 1'b0;
		@(posedge clk);
		while (pending_cnt != 0)
			@(posedge clk);
	endtask

	task automatic load_registers(input cfg_t c);
		reg_index_t idx;
		idx = idx.first();
		do begin
			cfg_we <= 1'b1;
			cfg_index <= idx;
			case (idx)
				REG_RESET_LOW: cfg_data <= CFG_DATA_W'(c.reset_low_ticks);
				REG_PRESENCE_WINDOW: cfg_data <= CFG_DATA_W'(c.presence_window_ticks);
				REG_RELEASE_WAIT: cfg_data <= CFG_DATA_W'(c.release_wait_ticks);
				REG_WRITE_SLOT: cfg_data <= CFG_DATA_W'(c.write_slot_ticks);
				REG_READ_SAMPLE: cfg_data <= CFG_DATA_W'(c.read_sample_ticks);
				REG_READ_RECOVER: cfg_data <= CFG_DATA_W'(c.read_recover_ticks);
				REG_POLL_INTERVAL: cfg_data <= CFG_DATA_W'(c.poll_interval_ticks);
				default: cfg_data <= CFG_DATA_W'(c.poll_limit);
			endcase
			@(posedge clk);
			idx = idx.next();
		end while (idx != idx.first());
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input cfg_t c, input int idle_pct, input int stall,
			input bit pressure, input int one_pct, input int items);
		load_registers(c);
		send_idle_pct = idle_pct;
		stall_pct = stall;
		pressure_on = pressure;
		repeat (items)
			send_tick($urandom_range(0, 99) < 30, $urandom_range(0, 99) < one_pct);
		drain();
		pressure_on = 1'b0;
	endtask

	initial begin : stimulus
		cfg_t rand_cfg;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Shortest timings: a start while idle, starts ignored while busy, no presence.
		load_registers(cfg_t'{10'd1, 8'd1, 10'd0, 8'd1, 6'd1, 8'd1, 16'd1, 8'd1});
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);
		drain();

		run_phase(cfg_t'{10'd2, 8'd3, 10'd2, 8'd1, 6'd1, 8'd1, 16'd3, 8'd3},
			0, 0, 1'b0, 50, 450);
		// Mostly low line: polls read zero and run into the limit.
		run_phase(cfg_t'{10'd1, 8'd2, 10'd2, 8'd1, 6'd1, 8'd1, 16'd2, 8'd2},
			0, 53, 1'b0, 3, 250);
		// Mostly high line: presence windows pass without a presence low.
		run_phase(cfg_t'{10'd2, 8'd1, 10'd1, 8'd1, 6'd1, 8'd2, 16'd1, 8'd1},
			29, 29, 1'b0, 92, 200);
		run_phase(cfg_t'{10'd1023, 8'd255, 10'd1023, 8'd255, 6'd63, 8'd255, 16'd65535, 8'd255},
			0, 0, 1'b1, 50, 150);

		rand_cfg.reset_low_ticks = 10'($urandom_range(1, 6));
		rand_cfg.presence_window_ticks = 8'($urandom_range(1, 8));
		rand_cfg.release_wait_ticks = 10'($urandom_range(0, 6));
		rand_cfg.write_slot_ticks = 8'($urandom_range(1, 3));
		rand_cfg.read_sample_ticks = 6'($urandom_range(1, 3));
		rand_cfg.read_recover_ticks = 8'($urandom_range(1, 3));
		rand_cfg.poll_interval_ticks = 16'($urandom_range(1, 20));
		rand_cfg.poll_limit = 8'($urandom_range(1, 4));
		run_phase(rand_cfg, 53, 0, 1'b0, 45, 350);

		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
src/owtr_pkg.sv
src/owtr_stream_if.sv
src/owtr_seq.sv
src/one_wire_temperature_reader_core.sv
verif/owtr_status_checker.sv
verif/tb_one_wire_temperature_reader_core.sv
